### hw/rtl/i2c_bit_level_master_top_assert.svh
// Assertion macros for the I2C bit-level master.
`ifndef I2C_BIT_LEVEL_MASTER_TOP_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_ASSERT_SVH

`ifndef SYNTH

`define I2CM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define I2CM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CM_ASSERT_IMP(lbl, ante, cons, msg)

`define I2CM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_STOP  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_WAIT  = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_POST_GAP    = 2'd2;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd20;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd250;
  localparam logic [15:0] POST_GAP_RESET    = 16'd200;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       ready_res;
    logic       cmd_done;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       timed_out;
  } res_t;

endpackage

### hw/rtl/i2c_bit_level_master_top.sv
// I2C bit-level master. Every input beat is one bus tick carrying an optional command
// (start, stop, write byte, wait for acknowledge, read byte with ACK/NACK) and the sampled
// SDA level; every input beat yields exactly one result beat showing SCL, SDA, drive
// enable, idle, done and the read/acknowledge status after that tick. One beat is taken
// per cycle while in_stall is low: the bus sequencer and its tick counters update in a
// single pass, and a result register plus a one-deep skid stage keep input flowing while
// the output side stalls, so in_stall rises only when both are full. Half-bit timing,
// acknowledge timeout and the post-acknowledge gap are counted in ticks and set through
// the cfg port (indices 0, 1, 2) by the user while the block is idle; nothing enforces it.
`include "i2c_bit_level_master_top_assert.svh"

module i2c_bit_level_master_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd_valid,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_write_byte,
  input  logic        in_send_ack,
  input  logic        in_sda_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_sda_drive,
  output logic        out_ready_res,
  output logic        out_cmd_done,
  output logic [7:0]  out_read_data,
  output logic        out_ack_seen,
  output logic        out_timed_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B, PH_WR_LOW, PH_WR_HIGH,
    PH_AK_SETUP, PH_AK_POLL, PH_BIT9_HIGH, PH_GAP, PH_RD_LOW, PH_RD_HIGH, PH_MA_SETUP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [7:0]  read_r, read_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        drive_r, drive_nxt;
  logic        ack_r, ack_nxt;
  logic        tmo_r, tmo_nxt;
  logic        ack_send_r, ack_send_nxt;
  logic        done;

  logic [15:0] half_r, ack_lim_r, gap_r;

  i2cm_pkg::res_t res, out_r, skid_r;
  logic           out_valid_r, skid_valid_r;
  logic           in_fire;

  logic [15:0] half_len, ack_len, tick_inc, wait_inc;
  logic        half_end, gap_end;
  logic [7:0]  rd_shift;

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign cfg_ready = 1'b1;

  assign half_len = (half_r == 16'd0) ? 16'd1 : half_r;
  assign ack_len  = (ack_lim_r == 16'd0) ? 16'd1 : ack_lim_r;
  assign tick_inc = tick_r + 16'd1;
  assign wait_inc = wait_r + 16'd1;
  assign half_end = ({1'b0, tick_r} + 17'd1) >= {1'b0, half_len};
  assign gap_end  = ({1'b0, tick_r} + 17'd1) >= {1'b0, ((gap_r == 16'd0) ? 16'd1 : gap_r)};
  assign rd_shift = {shift_r[6:0], in_sda_line};

  always_comb begin
    phase_nxt    = phase_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    tick_nxt     = tick_r;
    wait_nxt     = wait_r;
    read_nxt     = read_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    drive_nxt    = drive_r;
    ack_nxt      = ack_r;
    tmo_nxt      = tmo_r;
    ack_send_nxt = ack_send_r;
    done         = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_cmd_valid) begin
          unique case (in_req_type)
            i2cm_pkg::REQ_START: begin
              tick_nxt = 16'd0; bit_idx_nxt = 3'd0;
              sda_nxt = 1'b1; drive_nxt = 1'b1; phase_nxt = PH_ST_A;
            end
            i2cm_pkg::REQ_STOP: begin
              tick_nxt = 16'd0; bit_idx_nxt = 3'd0;
              scl_nxt = 1'b0; sda_nxt = 1'b0; drive_nxt = 1'b1; phase_nxt = PH_SP_A;
            end
            i2cm_pkg::REQ_WRITE: begin
              tick_nxt = 16'd0; bit_idx_nxt = 3'd0;
              shift_nxt = in_write_byte;
              scl_nxt = 1'b0; drive_nxt = 1'b1; sda_nxt = in_write_byte[7];
              phase_nxt = PH_WR_LOW;
            end
            i2cm_pkg::REQ_WAIT: begin
              tick_nxt = 16'd0; bit_idx_nxt = 3'd0;
              ack_nxt = 1'b0; tmo_nxt = 1'b0;
              scl_nxt = 1'b0; sda_nxt = 1'b1; drive_nxt = 1'b0;
              wait_nxt = 16'd0; phase_nxt = PH_AK_SETUP;
            end
            i2cm_pkg::REQ_READ: begin
              tick_nxt = 16'd0; bit_idx_nxt = 3'd0;
              ack_send_nxt = in_send_ack; shift_nxt = 8'd0;
              scl_nxt = 1'b0; sda_nxt = 1'b1; drive_nxt = 1'b0;
              phase_nxt = PH_RD_LOW;
            end
            default: begin
            end
          endcase
        end
      end
      PH_ST_A: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          scl_nxt = 1'b1; phase_nxt = PH_ST_B;
        end
      end
      PH_ST_B: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          sda_nxt = 1'b0; phase_nxt = PH_ST_C;
        end
      end
      PH_ST_C: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          scl_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1;
        end
      end
      PH_SP_A: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          scl_nxt = 1'b1; phase_nxt = PH_SP_B;
        end
      end
      PH_SP_B: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          sda_nxt = 1'b1; drive_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1;
        end
      end
      PH_WR_LOW: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          scl_nxt = 1'b1; phase_nxt = PH_WR_HIGH;
        end
      end
      PH_WR_HIGH: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          scl_nxt = 1'b0;
          if (bit_idx_r == 3'd7) begin
            bit_idx_nxt = 3'd0; phase_nxt = PH_IDLE; done = 1'b1;
          end else begin
            bit_idx_nxt = bit_idx_r + 3'd1;
            shift_nxt = {shift_r[6:0], 1'b0};
            sda_nxt = shift_r[6];
            phase_nxt = PH_WR_LOW;
          end
        end
      end
      PH_AK_SETUP: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          wait_nxt = 16'd0; phase_nxt = PH_AK_POLL;
        end
      end
      PH_AK_POLL: begin
        if (!in_sda_line) begin
          ack_nxt = 1'b1; scl_nxt = 1'b1; tick_nxt = 16'd0; phase_nxt = PH_BIT9_HIGH;
        end else begin
          wait_nxt = wait_inc;
          if (wait_inc >= ack_len || wait_inc == 16'd0) begin
            tmo_nxt = 1'b1; ack_nxt = 1'b0;
            sda_nxt = 1'b0; drive_nxt = 1'b1;
            tick_nxt = 16'd0; phase_nxt = PH_SP_A;
          end
        end
      end
      PH_BIT9_HIGH: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          scl_nxt = 1'b0;
          if (gap_r == 16'd0) begin
            phase_nxt = PH_IDLE; done = 1'b1;
          end else begin
            phase_nxt = PH_GAP;
          end
        end
      end
      PH_GAP: begin
        tick_nxt = gap_end ? 16'd0 : tick_inc;
        if (gap_end) begin
          phase_nxt = PH_IDLE; done = 1'b1;
        end
      end
      PH_RD_LOW: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          scl_nxt = 1'b1; phase_nxt = PH_RD_HIGH;
        end
      end
      PH_RD_HIGH: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          shift_nxt = rd_shift;
          scl_nxt = 1'b0;
          if (bit_idx_r == 3'd7) begin
            bit_idx_nxt = 3'd0;
            read_nxt = rd_shift;
            drive_nxt = 1'b1;
            sda_nxt = !ack_send_r;
            phase_nxt = PH_MA_SETUP;
          end else begin
            bit_idx_nxt = bit_idx_r + 3'd1;
            phase_nxt = PH_RD_LOW;
          end
        end
      end
      PH_MA_SETUP: begin
        tick_nxt = half_end ? 16'd0 : tick_inc;
        if (half_end) begin
          scl_nxt = 1'b1; phase_nxt = PH_BIT9_HIGH;
        end
      end
      default: begin
        phase_nxt = PH_IDLE; tick_nxt = 16'd0;
      end
    endcase
  end

  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = drive_nxt ? sda_nxt : 1'b1;
    res.sda_drive = drive_nxt;
    res.ready_res = (phase_nxt == PH_IDLE);
    res.cmd_done  = done;
    res.read_data = read_nxt;
    res.ack_seen  = ack_nxt;
    res.timed_out = tmo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_idx_r    <= 3'd0;
      shift_r      <= 8'd0;
      tick_r       <= 16'd0;
      wait_r       <= 16'd0;
      read_r       <= 8'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      drive_r      <= 1'b0;
      ack_r        <= 1'b0;
      tmo_r        <= 1'b0;
      ack_send_r   <= 1'b0;
      half_r       <= i2cm_pkg::HALF_PERIOD_RESET;
      ack_lim_r    <= i2cm_pkg::ACK_TIMEOUT_RESET;
      gap_r        <= i2cm_pkg::POST_GAP_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r    <= phase_nxt;
        bit_idx_r  <= bit_idx_nxt;
        shift_r    <= shift_nxt;
        tick_r     <= tick_nxt;
        wait_r     <= wait_nxt;
        read_r     <= read_nxt;
        scl_r      <= scl_nxt;
        sda_r      <= sda_nxt;
        drive_r    <= drive_nxt;
        ack_r      <= ack_nxt;
        tmo_r      <= tmo_nxt;
        ack_send_r <= ack_send_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          i2cm_pkg::CFG_HALF_PERIOD: half_r    <= cfg_data;
          i2cm_pkg::CFG_ACK_TIMEOUT: ack_lim_r <= cfg_data;
          i2cm_pkg::CFG_POST_GAP:    gap_r     <= cfg_data;
          default: begin
          end
        endcase
      end
      if (!out_valid_r || !out_stall) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else if (in_fire) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (in_fire) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_out   = out_r.scl_out;
  assign out_sda_out   = out_r.sda_out;
  assign out_sda_drive = out_r.sda_drive;
  assign out_ready_res = out_r.ready_res;
  assign out_cmd_done  = out_r.cmd_done;
  assign out_read_data = out_r.read_data;
  assign out_ack_seen  = out_r.ack_seen;
  assign out_timed_out = out_r.timed_out;

  `I2CM_ASSERT_IMP(a_skid_implies_out, skid_valid_r, out_valid_r, "skid full with empty output")
  `I2CM_ASSERT_NXT(a_stall_fills_skid, in_fire && out_valid_r && out_stall, skid_valid_r, "beat lost on output stall")
  `I2CM_ASSERT_IMP(a_released_high, out_valid_r && !out_r.sda_drive, out_r.sda_out, "released SDA not high")
  `I2CM_ASSERT_IMP(a_bit_idx_phase, bit_idx_r != 3'd0, phase_r == PH_WR_LOW || phase_r == PH_WR_HIGH || phase_r == PH_RD_LOW || phase_r == PH_RD_HIGH, "bit index outside byte phases")

endmodule
